// ----- rtl/hpm_pkg.sv -----
// Shared types and constants of the hyperspectral predictor and mapper.
// Used by the interfaces, the configuration block, the core and the top level.
`default_nettype none
package hpm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GEO_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_BITS       = 3'd0,
		REG_WEIGHT_RESOLUTION = 3'd1,
		REG_REGISTER_SIZE     = 3'd2,
		REG_NARROW_LOCAL_SUM  = 3'd3,
		REG_PREDICTION_BANDS  = 3'd4,
		REG_FRAME_WIDTH       = 3'd5,
		REG_FRAME_HEIGHT      = 3'd6
	} cfg_reg_t;

	// Configuration after clamping to the legal ranges.
	typedef struct packed {
		logic [4:0]       d;
		logic [4:0]       om;
		logic [6:0]       r;
		logic             narrow;
		logic [1:0]       p;
		logic [GEO_W-1:0] w;
		logic [GEO_W-1:0] h;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mapped;
		logic [SAMPLE_W-1:0] pred;
		logic                band_end;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/hpm_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on hpm_pkg for field widths.
`default_nettype none
interface hpm_in_if;
	logic                         valid;
	logic                         ready;
	logic [hpm_pkg::SAMPLE_W-1:0] sample;
	logic                         image_start;
	modport source (output valid, sample, image_start, input ready);
	modport sink (input valid, sample, image_start, output ready);
endinterface

interface hpm_out_if;
	logic                         valid;
	logic                         ready;
	logic [hpm_pkg::SAMPLE_W-1:0] mapped_index;
	logic [hpm_pkg::SAMPLE_W-1:0] prediction;
	logic                         band_end;
	modport source (output valid, mapped_index, prediction, band_end, input ready);
	modport sink (input valid, mapped_index, prediction, band_end, output ready);
endinterface

interface hpm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hpm_pkg::CFG_IDX_W-1:0]  index;
	logic [hpm_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/hyperspectral_predictor_mapper.sv -----
// An accepted item steps through neighbor reads and sum, then a plane read and MAC per
// band for Pz = min(P, bands seen) bands (none for a band's first sample), reduction,
// clip and mapping into the output register; the single shared multiplier and plane
// memory read port serialize this, and no new item is taken until the last is mapped.
// Reset clears counters, band pointer, neighbor holds and the output valid flag;
// the line, first-row and difference-plane memories are not cleared.
`default_nettype none
module hyperspectral_predictor_mapper #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int MAX_PRED_BANDS = 3
) (
	input wire logic  clk,
	input wire logic  arst_n,
	hpm_in_if.sink    pixels,
	hpm_out_if.source residuals,
	hpm_cfg_if.sink   cfg
);
	hpm_pkg::cfg_t    cfg_c;
	hpm_pkg::result_t res, res_q;
	logic res_load, res_free, out_valid_q;

	hpm_cfg_regs #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_PRED_BANDS(MAX_PRED_BANDS)
	) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cfg_o(cfg_c)
	);

	hpm_core #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_PRED_BANDS(MAX_PRED_BANDS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_c), .pixels(pixels),
		.res(res), .res_load(res_load), .res_free(res_free)
	);

	// Output holding register: the core may start the next item while it waits.
	assign res_free = !out_valid_q || residuals.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (residuals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	assign residuals.valid        = out_valid_q;
	assign residuals.mapped_index = res_q.mapped;
	assign residuals.prediction   = res_q.pred;
	assign residuals.band_end     = res_q.band_end;
endmodule
`default_nettype wire

// ----- rtl/hpm_cfg_regs.sv -----
// Configuration register file with range clamping.
// Depends on hpm_pkg and hpm_cfg_if.
`default_nettype none
module hpm_cfg_regs #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int MAX_PRED_BANDS = 3
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hpm_cfg_if.sink        cfg,
	output hpm_pkg::cfg_t  cfg_o
);
	localparam int GW = hpm_pkg::GEO_W;

	logic [4:0] d_q, om_q;
	logic [6:0] r_q, w_q, h_q;
	logic       narrow_q;
	logic [1:0] p_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q      <= 5'd16;
			om_q     <= 5'd13;
			r_q      <= 7'd64;
			narrow_q <= 1'b0;
			p_q      <= 2'd3;
			w_q      <= 7'd64;
			h_q      <= 7'd64;
		end else if (cfg.valid) begin
			case (cfg.index)
				hpm_pkg::REG_SAMPLE_BITS:       d_q      <= cfg.data[4:0];
				hpm_pkg::REG_WEIGHT_RESOLUTION: om_q     <= cfg.data[4:0];
				hpm_pkg::REG_REGISTER_SIZE:     r_q      <= cfg.data;
				hpm_pkg::REG_NARROW_LOCAL_SUM:  narrow_q <= cfg.data[0];
				hpm_pkg::REG_PREDICTION_BANDS:  p_q      <= cfg.data[1:0];
				hpm_pkg::REG_FRAME_WIDTH:       w_q      <= cfg.data;
				hpm_pkg::REG_FRAME_HEIGHT:      h_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_o.d  = (d_q < 5'd2) ? 5'd2 : ((d_q > 5'd16) ? 5'd16 : d_q);
		cfg_o.om = (om_q < 5'd4) ? 5'd4 : ((om_q > 5'd19) ? 5'd19 : om_q);
		cfg_o.r  = (r_q < 7'd32) ? 7'd32 : ((r_q > 7'd64) ? 7'd64 : r_q);
		cfg_o.narrow = narrow_q;
		cfg_o.p  = (int'(p_q) > MAX_PRED_BANDS) ? 2'(MAX_PRED_BANDS) : p_q;
		cfg_o.w  = (w_q == 7'd0) ? GW'(1) :
			((int'(w_q) > MAX_WIDTH) ? GW'(MAX_WIDTH) : GW'(w_q));
		cfg_o.h  = (h_q == 7'd0) ? GW'(1) :
			((int'(h_q) > MAX_HEIGHT) ? GW'(MAX_HEIGHT) : GW'(h_q));
	end
endmodule
`default_nettype wire

// ----- rtl/hpm_core.sv -----
// Sequencer, neighbor stores, central-difference planes and the shared MAC.
// Depends on hpm_pkg and hpm_in_if.
`default_nettype none
module hpm_core #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int MAX_PRED_BANDS = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  hpm_pkg::cfg_t     cfg,
	hpm_in_if.sink            pixels,
	output hpm_pkg::result_t  res,
	output logic              res_load,
	input  wire logic         res_free
);
	localparam int GW = hpm_pkg::GEO_W;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = $clog2(MAX_PRED_BANDS + 1);
	localparam int AW = PW + YW + XW;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD_N  = 9'b000000010,
		S_RD_NE = 9'b000000100,
		S_SUM   = 9'b000001000,
		S_MRD   = 9'b000010000,
		S_MAC   = 9'b000100000,
		S_RED   = 9'b001000000,
		S_CLIP  = 9'b010000000,
		S_MAP   = 9'b100000000
	} state_t;

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == PW'(MAX_PRED_BANDS)) ? v : v + PW'(1);
	endfunction

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
		return (v == PW'(MAX_PRED_BANDS)) ? PW'(0) : v + PW'(1);
	endfunction

	state_t state_q;
	logic [XW-1:0] col_q, x_q, ne_q;
	logic [YW-1:0] row_q, y_q;
	logic [PW-1:0] bands_q, plane_q, bs_q, pcur_q, pl_q, cnt_q;
	logic [15:0]   west_q, nw_q, prior_hold_q, pbfs_q, s_q, n_raw_q;
	logic          first_q, last_q, xlast_q;
	logic signed [63:0] acc_q, red_q;
	logic [18:0]   wt_q;
	logic [16:0]   dbl_q;

	logic [15:0] line_mem [2**XW];
	logic [15:0] pbfr_mem [2**XW];
	logic signed [18:0] plane_mem [2**AW];
	logic [15:0] line_rdata, pbfr_rdata;
	logic signed [18:0] plane_rdata;
	logic [XW-1:0] line_raddr;
	logic [PW-1:0] pl_rd;

	logic accept;
	assign pixels.ready = (state_q == S_IDLE);
	assign accept = pixels.valid && pixels.ready;

	// Position of the accepted item and the counters that follow it.
	logic [GW-1:0] col0, row0, col1, row1, colN, rowN, x1p, y1p;
	logic [PW-1:0] bs0, pl0, bs1, pl1, bsN, plN;
	logic [15:0]   smax16, smid16;

	assign smax16 = 16'((17'(1) << cfg.d) - 17'(1));
	assign smid16 = 16'(17'(1) << (cfg.d - 5'd1));

	always_comb begin
		col0 = pixels.image_start ? GW'(0) : GW'(col_q);
		row0 = pixels.image_start ? GW'(0) : GW'(row_q);
		bs0  = pixels.image_start ? PW'(0) : bands_q;
		pl0  = pixels.image_start ? PW'(0) : plane_q;
		col1 = col0;
		row1 = row0;
		bs1  = bs0;
		pl1  = pl0;
		if (col0 >= cfg.w) begin
			col1 = GW'(0);
			row1 = row0 + GW'(1);
		end
		if (row1 >= cfg.h) begin
			row1 = GW'(0);
			bs1  = sat_inc(bs0);
			pl1  = wrap_inc(pl0);
		end
		x1p  = col1 + GW'(1);
		y1p  = row1 + GW'(1);
		colN = x1p;
		rowN = row1;
		bsN  = bs1;
		plN  = pl1;
		if (x1p >= cfg.w) begin
			colN = GW'(0);
			if (y1p >= cfg.h) begin
				rowN = GW'(0);
				bsN  = sat_inc(bs1);
				plN  = wrap_inc(pl1);
			end else begin
				rowN = y1p;
			end
		end
	end

	// Local sum and central difference.
	logic [17:0] nn, ne, nw, ws, sigma, s4;
	logic signed [19:0] dc, sdiff;
	always_comb begin
		nn = (y_q != '0) ? 18'(n_raw_q) : 18'd0;
		ne = (y_q != '0) ? 18'(line_rdata) : 18'd0;
		nw = (y_q != '0) ? 18'(nw_q) : 18'd0;
		ws = 18'(west_q);
		s4 = 18'(s_q) << 2;
		sigma = 18'd0;
		if (!cfg.narrow) begin
			if (y_q != '0 && x_q != '0 && !xlast_q) sigma = ws + nw + nn + ne;
			else if (y_q == '0 && x_q != '0) sigma = ws << 2;
			else if (y_q != '0 && x_q == '0) sigma = (nn + ne) << 1;
			else if (y_q != '0 && xlast_q) sigma = ws + nw + (nn << 1);
		end else begin
			if (y_q != '0 && x_q != '0 && !xlast_q) sigma = nw + (nn << 1) + ne;
			else if (y_q == '0 && x_q != '0 && bs_q != '0)
				sigma = 18'(prior_hold_q) << 2;
			else if (y_q != '0 && x_q == '0) sigma = (nn + ne) << 1;
			else if (y_q != '0 && xlast_q) sigma = (nw + nn) << 1;
			else if (y_q == '0 && x_q != '0) sigma = 18'(smid16) << 2;
		end
		dc    = first_q ? 20'sd0 : $signed(20'(s4)) - $signed(20'(sigma));
		sdiff = $signed(20'(sigma)) - $signed(20'(18'(smid16) << 2));
	end

	// Shared multiplier of the inner product.
	logic signed [38:0] prod;
	assign prod = $signed({1'b0, wt_q}) * plane_rdata;
	assign pl_rd = (pl_q == '0) ? PW'(MAX_PRED_BANDS) : pl_q - PW'(1);

	// Reduction, clip and mapping.
	logic [6:0]  sh;
	logic signed [63:0] offs, hmax, hr;
	logic [16:0] dbl_n;
	logic [15:0] pred;
	logic signed [17:0] theta, pdiff;
	logic signed [17:0] q;
	logic [16:0] aq, mapped;
	logic        sq_nonneg;
	always_comb begin
		sh   = 7'd64 - cfg.r;
		offs = $signed(((64'(1) << (cfg.d + 5'd1)) + 64'(2)) << cfg.om);
		hmax = $signed(((64'(1) << (cfg.d + 5'd2)) - 64'(2)) << cfg.om);
		hr   = red_q + offs;
		if (hr < 0) hr = 64'sd0;
		if (hr > hmax) hr = hmax;
		if (!first_q) dbl_n = 17'(hr >>> (cfg.om + 5'd1));
		else if (cfg.p != 2'd0 && bs_q != '0) dbl_n = {pbfs_q, 1'b0};
		else dbl_n = {smid16, 1'b0};

		// a prior-band first sample may exceed the current range; keep theta signed
		pred  = dbl_q[16:1];
		pdiff = $signed({2'b00, smax16}) - $signed({2'b00, pred});
		theta = ($signed({2'b00, pred}) < pdiff) ? $signed({2'b00, pred}) : pdiff;
		q     = $signed({2'b00, s_q}) - $signed({2'b00, pred});
		aq    = q[17] ? 17'(-q) : 17'(q);
		sq_nonneg = dbl_q[0] ? (q <= 0) : (q >= 0);
		if ($signed({1'b0, aq}) > theta) mapped = 17'($signed({1'b0, aq}) + theta);
		else if (sq_nonneg) mapped = aq << 1;
		else mapped = (aq << 1) - 17'd1;
	end

	assign res_load     = (state_q == S_MAP) && res_free;
	assign res.mapped   = mapped[15:0];
	assign res.pred     = pred;
	assign res.band_end = last_q;

	assign line_raddr = (state_q == S_RD_N) ? x_q : ne_q;

	always_ff @(posedge clk) begin
		line_rdata  <= line_mem[line_raddr];
		pbfr_rdata  <= pbfr_mem[x_q];
		plane_rdata <= plane_mem[{pl_rd, y_q, x_q}];
		if (state_q == S_SUM) begin
			line_mem[x_q] <= s_q;
			plane_mem[{pcur_q, y_q, x_q}] <= dc[18:0];
			if (y_q == '0) pbfr_mem[x_q] <= s_q;
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= XW'(col1);
			y_q     <= YW'(row1);
			ne_q    <= (x1p < cfg.w) ? XW'(x1p) : XW'(cfg.w - GW'(1));
			s_q     <= pixels.sample & smax16;
			first_q <= (col1 == '0) && (row1 == '0);
			xlast_q <= (x1p == cfg.w);
			last_q  <= (x1p == cfg.w) && (y1p == cfg.h);
			bs_q    <= bs1;
			pcur_q  <= pl1;
		end
		case (state_q)
			S_RD_NE: n_raw_q <= line_rdata;
			S_SUM: begin
				acc_q <= 64'(sdiff) <<< cfg.om;
				wt_q  <= 19'((23'(7) << cfg.om) >> 3);
				pl_q  <= pcur_q;
				if (first_q) cnt_q <= PW'(0);
				else cnt_q <= (int'(bs_q) < int'(cfg.p)) ? bs_q : PW'(cfg.p);
			end
			S_MRD: pl_q <= pl_rd;
			S_MAC: begin
				acc_q <= acc_q + 64'(prod);
				wt_q  <= wt_q >> 3;
				cnt_q <= cnt_q - PW'(1);
			end
			S_RED: red_q <= (acc_q <<< sh) >>> sh;
			S_CLIP: dbl_q <= dbl_n;
			default: ;
		endcase
	end

	// Control state: counters, neighbor holds and the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			bands_q      <= '0;
			plane_q      <= '0;
			west_q       <= '0;
			nw_q         <= '0;
			prior_hold_q <= '0;
			pbfs_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) begin
					col_q   <= XW'(colN);
					row_q   <= YW'(rowN);
					bands_q <= bsN;
					plane_q <= plN;
					state_q <= S_RD_N;
				end
				S_RD_N:  state_q <= S_RD_NE;
				S_RD_NE: state_q <= S_SUM;
				S_SUM: begin
					nw_q   <= n_raw_q;
					west_q <= s_q;
					if (y_q == '0) prior_hold_q <= pbfr_rdata;
					state_q <= (!first_q && bs_q != '0 && cfg.p != 2'd0) ? S_MRD : S_RED;
				end
				S_MRD: state_q <= S_MAC;
				S_MAC: state_q <= (cnt_q > PW'(1)) ? S_MRD : S_RED;
				S_RED: state_q <= S_CLIP;
				S_CLIP: state_q <= S_MAP;
				S_MAP: if (res_free) begin
					if (first_q) pbfs_q <= s_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RD_N) else $error("accepted item did not start a read");
	a_mac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> cnt_q != '0) else $error("MAC step with no band left");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free && state_q == S_MAP) else $error("result loaded into busy slot");
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(plane_q) <= MAX_PRED_BANDS && int'(bands_q) <= MAX_PRED_BANDS)
		else $error("plane pointer or band count out of range");
endmodule
`default_nettype wire
